### design/ackfp_pkg.sv
// ackfp_pkg: types and constants of the ACK frame parser.
// No dependencies; used by ack_frame_parser.
package ackfp_pkg;

  localparam logic [7:0] SOF_BYTE = 8'hAA;
  localparam logic [7:0] ACK_CMD  = 8'h81;
  localparam logic [7:0] ACK_LEN  = 8'd2;

  typedef enum logic [4:0] {
    PH_HUNT = 5'b00001,
    PH_CMD  = 5'b00010,
    PH_LEN  = 5'b00100,
    PH_PAY  = 5'b01000,
    PH_CHK  = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_OK   = 2'd1,
    EV_NACK = 2'd2,
    EV_BAD  = 2'd3
  } event_t;

endpackage

### design/ack_frame_parser.sv
// ack_frame_parser: byte-wise parser for 0xAA/cmd/len/payload/check frames,
// counting good acks and bad frames (nacks, check mismatches). Depends on ackfp_pkg.
//
// channel  direction  handshake                   payload
// in_      input      in_valid / in_stall         in_rx_byte
// out_     output     out_valid / out_stall       out_event_res .. out_bad_count
//
// One result per byte, valid the cycle after; a byte is taken every cycle that in_stall is low.
// Frame state updates at the input edge; the result register holds the fields.
// in_stall rises only while a result is held and out_stall is high.
// rst_n (synchronous) returns the parser to hunting and clears both counters.
module ack_frame_parser #(
  parameter int MAX_PAYLOAD = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_res,
  output logic [7:0]  out_frame_code,
  output logic [7:0]  out_acked_code,
  output logic [7:0]  out_ack_status,
  output logic [7:0]  out_expected_check,
  output logic [31:0] out_ok_count,
  output logic [31:0] out_bad_count
);

  localparam int LW = $clog2(MAX_PAYLOAD + 1);

  ackfp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic [7:0]  head_r [2];
  logic [31:0] good_r, good_nxt;
  logic [31:0] bad_r, bad_nxt;

  logic        valid_r;
  ackfp_pkg::event_t ev_r, ev_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [7:0]  acked_r, acked_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [7:0]  expect_r, expect_nxt;

  logic in_acc;
  logic [LW:0] idx_inc;
  logic len_over;
  logic is_ack;

  assign in_stall = valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign idx_inc  = {1'b0, idx_r} + {{LW{1'b0}}, 1'b1};
  assign len_over = {1'b0, in_rx_byte} > 9'(MAX_PAYLOAD);
  assign is_ack   = (cmd_r == ackfp_pkg::ACK_CMD) &&
                    ({{(8 > LW ? 8 - LW : 0){1'b0}}, len_r} == 8'(ackfp_pkg::ACK_LEN));

  always_comb begin
    phase_nxt  = phase_r;
    cmd_nxt    = cmd_r;
    len_nxt    = len_r;
    sum_nxt    = sum_r;
    idx_nxt    = idx_r;
    good_nxt   = good_r;
    bad_nxt    = bad_r;
    ev_nxt     = ackfp_pkg::EV_NONE;
    code_nxt   = 8'd0;
    acked_nxt  = 8'd0;
    status_nxt = 8'd0;
    expect_nxt = 8'd0;
    case (phase_r)
      ackfp_pkg::PH_HUNT: begin
        if (in_rx_byte == ackfp_pkg::SOF_BYTE) phase_nxt = ackfp_pkg::PH_CMD;
      end
      ackfp_pkg::PH_CMD: begin
        cmd_nxt   = in_rx_byte;
        sum_nxt   = in_rx_byte;
        phase_nxt = ackfp_pkg::PH_LEN;
      end
      ackfp_pkg::PH_LEN: begin
        len_nxt = LW'(in_rx_byte);
        sum_nxt = sum_r + in_rx_byte;
        idx_nxt = '0;
        if (len_over) phase_nxt = ackfp_pkg::PH_HUNT;
        else if (in_rx_byte == 8'd0) phase_nxt = ackfp_pkg::PH_CHK;
        else phase_nxt = ackfp_pkg::PH_PAY;
      end
      ackfp_pkg::PH_PAY: begin
        idx_nxt = idx_inc[LW-1:0];
        sum_nxt = sum_r + in_rx_byte;
        if (idx_inc >= {1'b0, len_r}) phase_nxt = ackfp_pkg::PH_CHK;
      end
      ackfp_pkg::PH_CHK: begin
        phase_nxt = ackfp_pkg::PH_HUNT;
        if (in_rx_byte == sum_r) begin
          if (is_ack) begin
            code_nxt   = cmd_r;
            acked_nxt  = head_r[0];
            status_nxt = head_r[1];
            expect_nxt = sum_r;
            if (head_r[1] == 8'd0) begin
              good_nxt = good_r + 32'd1;
              ev_nxt   = ackfp_pkg::EV_OK;
            end else begin
              bad_nxt = bad_r + 32'd1;
              ev_nxt  = ackfp_pkg::EV_NACK;
            end
          end
        end else begin
          bad_nxt    = bad_r + 32'd1;
          ev_nxt     = ackfp_pkg::EV_BAD;
          code_nxt   = cmd_r;
          expect_nxt = sum_r;
        end
      end
      default: begin
        phase_nxt = ackfp_pkg::PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ackfp_pkg::PH_HUNT;
      cmd_r   <= 8'd0;
      len_r   <= '0;
      sum_r   <= 8'd0;
      idx_r   <= '0;
      good_r  <= 32'd0;
      bad_r   <= 32'd0;
      valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r <= phase_nxt;
        cmd_r   <= cmd_nxt;
        len_r   <= len_nxt;
        sum_r   <= sum_nxt;
        idx_r   <= idx_nxt;
        good_r  <= good_nxt;
        bad_r   <= bad_nxt;
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ev_r     <= ev_nxt;
      code_r   <= code_nxt;
      acked_r  <= acked_nxt;
      status_r <= status_nxt;
      expect_r <= expect_nxt;
      if (phase_r == ackfp_pkg::PH_PAY && idx_r < LW'(2)) begin
        head_r[idx_r[0]] <= in_rx_byte;
      end
    end
  end

  assign out_valid          = valid_r;
  assign out_event_res      = ev_r;
  assign out_frame_code     = code_r;
  assign out_acked_code     = acked_r;
  assign out_ack_status     = status_r;
  assign out_expected_check = expect_r;
  assign out_ok_count       = good_r;
  assign out_bad_count      = bad_r;

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result held");

  a_ok_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> ((ev_r == ackfp_pkg::EV_OK) == (good_r == $past(good_r) + 32'd1)))
    else $error("ok count out of step with ack event");

  a_bad_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (((ev_r == ackfp_pkg::EV_NACK) || (ev_r == ackfp_pkg::EV_BAD)) ==
                (bad_r == $past(bad_r) + 32'd1)))
    else $error("bad count out of step with nack or mismatch event");

  a_ok_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && ev_r == ackfp_pkg::EV_OK) |-> (status_r == 8'd0 && code_r == ackfp_pkg::ACK_CMD))
    else $error("ack ok reported with bad status or command");

  a_none_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && ev_r == ackfp_pkg::EV_NONE) |-> (code_r == 8'd0 && expect_r == 8'd0))
    else $error("fields set on a result with no event");

endmodule
